### design/vrap_pkg.sv
// Shared types, codes and address helpers for the video RAM access port.
package vrap_pkg;

  localparam int unsigned MEM_WORDS = 32768;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  localparam logic [2:0] OP_ADDR_LO = 3'd0;
  localparam logic [2:0] OP_ADDR_HI = 3'd1;
  localparam logic [2:0] OP_WR_LO   = 3'd2;
  localparam logic [2:0] OP_WR_HI   = 3'd3;
  localparam logic [2:0] OP_RD_LO   = 3'd4;
  localparam logic [2:0] OP_RD_HI   = 3'd5;

  localparam logic [1:0] CFG_STEP_SEL  = 2'd0;
  localparam logic [1:0] CFG_REMAP     = 2'd1;
  localparam logic [1:0] CFG_STEP_HI   = 2'd2;
  localparam logic [1:0] CFG_BLK_DIS   = 2'd3;

  localparam logic [1:0] REMAP_NONE = 2'd0;
  localparam logic [1:0] REMAP_R8   = 2'd1;
  localparam logic [1:0] REMAP_R9   = 2'd2;
  localparam logic [1:0] REMAP_R10  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic              cap_req;
    logic              exec;
    logic              load_ra;
    logic              out_load;
    logic              clr_we;
    logic [MEM_AW-1:0] clr_addr;
  } vrap_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fetch;
  } vrap_sts_t;

  // word address to memory index: rotate low 8/9/10 bits left by 3, keep 15 bits
  function automatic logic [MEM_AW-1:0] map_addr(input logic [15:0] a,
                                                 input logic [1:0]  remap);
    logic [14:0] m;
    unique case (remap)
      REMAP_R8:  m = {a[14:8],  a[4:0], a[7:5]};
      REMAP_R9:  m = {a[14:9],  a[5:0], a[8:6]};
      REMAP_R10: m = {a[14:10], a[6:0], a[9:7]};
      default:   m = a[14:0];
    endcase
    return m[MEM_AW-1:0];
  endfunction

  function automatic logic [15:0] step_size(input logic [1:0] sel);
    logic [15:0] s;
    unique case (sel)
      2'd0:    s = 16'd1;
      2'd1:    s = 16'd32;
      default: s = 16'd128;
    endcase
    return s;
  endfunction

endpackage

### design/vrap_mem.sv
// Video word memory with byte-lane writes and a registered read port.
module vrap_mem
  import vrap_pkg::*;
(
  input  logic              clk,
  input  logic              we_lo,
  input  logic              we_hi,
  input  logic [MEM_AW-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic [MEM_AW-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [0:MEM_WORDS-1];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_lo) begin
      mem[waddr][7:0] <= wdata[7:0];
    end
    if (we_hi) begin
      mem[waddr][15:8] <= wdata[15:8];
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/vrap_dp.sv
// Datapath: config registers, word address, read-ahead latch, request and result registers.
module vrap_dp
  import vrap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_byte_in,
  input  logic        in_forced_blank,
  input  logic        in_in_visible_lines,
  output logic [7:0]  out_byte_out,
  input  vrap_cmd_t   cmd,
  output vrap_sts_t   sts
);

  logic [1:0]  step_sel_r, remap_r;
  logic        step_hi_r, blk_dis_r;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] ra_r, ra_nxt;
  logic [2:0]  req_op_r;
  logic [7:0]  req_byte_r;
  logic        req_busy_r;
  logic [7:0]  res_r, res_nxt;
  logic [7:0]  out_data_r;

  logic        wr_ok, adv, wr_lo, wr_hi, addr_op;
  logic        mem_we_lo, mem_we_hi;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_sel_r <= '0;
      remap_r    <= '0;
      step_hi_r  <= 1'b0;
      blk_dis_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_SEL: step_sel_r <= cfg_data;
        CFG_REMAP:    remap_r    <= cfg_data;
        CFG_STEP_HI:  step_hi_r  <= cfg_data[0];
        CFG_BLK_DIS:  blk_dis_r  <= cfg_data[0];
      endcase
    end
  end

  assign wr_ok   = !req_busy_r || blk_dis_r;
  assign addr_op = (req_op_r == OP_ADDR_LO) || (req_op_r == OP_ADDR_HI);

  always_comb begin
    addr_nxt = addr_r;
    res_nxt  = res_r;
    adv      = 1'b0;
    wr_lo    = 1'b0;
    wr_hi    = 1'b0;
    if (cmd.exec) begin
      res_nxt = '0;
      unique case (req_op_r)
        OP_ADDR_LO: addr_nxt = {addr_r[15:8], req_byte_r};
        OP_ADDR_HI: addr_nxt = {req_byte_r, addr_r[7:0]};
        OP_WR_LO: begin
          wr_lo = wr_ok;
          adv   = !step_hi_r;
        end
        OP_WR_HI: begin
          wr_hi = wr_ok;
          adv   = step_hi_r;
        end
        OP_RD_LO: begin
          res_nxt = ra_r[7:0];
          adv     = !step_hi_r;
        end
        OP_RD_HI: begin
          res_nxt = ra_r[15:8];
          adv     = step_hi_r;
        end
        default: ;
      endcase
      if (adv) begin
        addr_nxt = addr_r + step_size(step_sel_r);
      end
    end
  end

  // stepping reads fetch at the old address; address sets fetch at the new one
  assign sts.fetch = addr_op
                  || ((req_op_r == OP_RD_LO) && !step_hi_r)
                  || ((req_op_r == OP_RD_HI) && step_hi_r);

  assign ra_nxt = cmd.load_ra ? (req_busy_r ? 16'd0 : mem_rdata) : ra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      ra_r   <= '0;
    end else begin
      addr_r <= addr_nxt;
      ra_r   <= ra_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      req_op_r   <= in_opcode;
      req_byte_r <= in_byte_in;
      req_busy_r <= !in_forced_blank && in_in_visible_lines;
    end
    res_r <= res_nxt;
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_byte_out = out_data_r;

  assign mem_we_lo = cmd.clr_we || wr_lo;
  assign mem_we_hi = cmd.clr_we || wr_hi;
  assign mem_waddr = cmd.clr_we ? cmd.clr_addr : map_addr(addr_r, remap_r);
  assign mem_wdata = cmd.clr_we ? 16'd0 : {req_byte_r, req_byte_r};
  assign mem_raddr = map_addr(addr_op ? addr_nxt : addr_r, remap_r);

  vrap_mem u_mem (
    .clk   (clk),
    .we_lo (mem_we_lo),
    .we_hi (mem_we_hi),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### design/vrap_ctrl.sv
// Controller: clearing pass, request sequencing and output handshake.
module vrap_ctrl
  import vrap_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  vrap_sts_t sts,
  output vrap_cmd_t cmd
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free, accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_FIN) && out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    cmd          = '0;
    cmd.clr_addr = clr_cnt_r;
    cmd.cap_req  = accept;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_we  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.fetch ? ST_LOAD : ST_FIN;
      end
      ST_LOAD: begin
        cmd.load_ra = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### design/video_ram_access_port_unit.sv
// Video RAM access port top level: controller, datapath and 32K x 16 video memory.
// After reset the block clears the whole video memory, one word per cycle;
// in_ready stays low during that pass while configuration writes are taken as
// usual. Each request then passes through the EXEC and FIN states (data writes,
// non-stepping reads, unused opcodes) or through EXEC, LOAD and FIN (address
// byte sets and stepping reads), LOAD covering the registered read of the single
// memory read port that refills the read-ahead latch. Every request gives one
// result byte on the out_ channel; a result waiting in the output register does
// not block the next request until that one finishes.
module video_ram_access_port_unit
  import vrap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_byte_in,
  input  logic       in_forced_blank,
  input  logic       in_in_visible_lines,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_out
);

  vrap_cmd_t cmd;
  vrap_sts_t sts;

  vrap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vrap_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_opcode           (in_opcode),
    .in_byte_in          (in_byte_in),
    .in_forced_blank     (in_forced_blank),
    .in_in_visible_lines (in_in_visible_lines),
    .out_byte_out        (out_byte_out),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule
